FILE: rtl/core/plin_pkg.sv
// ----------------------------------------------------------------------------
// plin_pkg
// Shared widths, codes and types of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package plin_pkg;

    localparam int DATA_W         = 32;
    localparam int CNT_W          = 7;
    localparam int IDX_W          = 6;
    localparam int STATUS_W       = 2;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam int MAX_POINTS_DEF = 64;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    localparam logic REG_POINT_COUNT = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FEW   = 2'd1,
        ST_NOSEG = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] x0;
        logic signed [DATA_W-1:0] y0;
        logic signed [DATA_W-1:0] x1;
        logic signed [DATA_W-1:0] y1;
    } t_seg;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] value;
        t_status                  status;
    } t_arith_rsp;

endpackage

FILE: rtl/core/piecewise_linear_interpolator_top.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_top
// Breakpoint table with segment search and fixed-point interpolation, rounded to nearest.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a clock edge with start high
//   and busy low. i_req_type selects a breakpoint write or an evaluation.
//   A write gives no result and leaves busy low; it is dropped when
//   i_point_index is not below the active point count.
//   An evaluation raises busy until o_done shows its result on
//   o_mapped_value / o_status for one cycle, the first cycle with busy low,
//   where the next transaction may be taken. With fewer than two points
//   the status is ST_FEW and busy stays low. A sample at or below the first
//   x uses the first segment, one at or above the last x the last; else the
//   one-entry-per-cycle scan finds the bracketing segment or gives ST_NOSEG;
//   a zero-width segment gives ST_ZERO, skipping the multiply and divide.
//   Configuration: APB register point_count at byte address 0, pready always
//   high; write only while busy is low and no result is pending.
//   Reset clears point_count; table entries then read as zero. The receiver
//   cannot stall, so each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_top #(
    parameter int MAX_POINTS = plin_pkg::MAX_POINTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_req_type,
    input  logic [plin_pkg::IDX_W-1:0]           i_point_index,
    input  logic signed [plin_pkg::DATA_W-1:0]   i_point_x,
    input  logic signed [plin_pkg::DATA_W-1:0]   i_point_y,
    input  logic signed [plin_pkg::DATA_W-1:0]   i_sample_x,
    output logic                                 o_done,
    output logic signed [plin_pkg::DATA_W-1:0]   o_mapped_value,
    output logic [plin_pkg::STATUS_W-1:0]        o_status,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [plin_pkg::PADDR_W-1:0]         paddr,
    input  logic [plin_pkg::PDATA_W-1:0]         pwdata,
    output logic [plin_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);
    import plin_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_CHK0,
        S_CHKL,
        S_SCAN0,
        S_SCAN,
        S_SEGA,
        S_SEGB,
        S_SEGC,
        S_WAIT
    } t_state;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_point_count;
    logic signed [DATA_W-1:0] r_sample;
    logic signed [DATA_W-1:0] r_prev;
    logic signed [DATA_W-1:0] r_x0;
    logic signed [DATA_W-1:0] r_y0;
    logic [AW-1:0]            r_k;
    logic [AW-1:0]            r_seg_i;
    logic                     r_done;
    logic signed [DATA_W-1:0] r_value;
    t_status                  r_status;

    logic [NW-1:0]            w_n;
    logic                     w_accept;
    logic                     w_wr_en;
    logic [AW-1:0]            w_rd_addr;
    logic signed [DATA_W-1:0] w_rd_x;
    logic signed [DATA_W-1:0] w_rd_y;
    logic                     w_cfg_wr;
    t_seg                     w_seg;
    t_arith_rsp               w_rsp;

    assign w_n = (32'(r_point_count) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS)
                                                        : NW'(r_point_count);
    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_wr_en  = w_accept && (i_req_type == REQ_WRITE)
                      && (32'(i_point_index) < 32'(w_n));

    always_comb begin
        case (r_state)
            S_CHK0:  w_rd_addr = AW'(w_n - NW'(1));
            S_SCAN:  w_rd_addr = AW'(r_k + 1'b1);
            S_SEGA:  w_rd_addr = r_seg_i;
            S_SEGB:  w_rd_addr = AW'(r_seg_i + 1'b1);
            default: w_rd_addr = '0;
        endcase
    end

    plin_tbl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(i_point_index)),
        .i_wr_x    (i_point_x),
        .i_wr_y    (i_point_y),
        .i_rd_addr (w_rd_addr),
        .o_rd_x    (w_rd_x),
        .o_rd_y    (w_rd_y)
    );

    assign w_seg = '{x: r_sample, x0: r_x0, y0: r_y0, x1: w_rd_x, y1: w_rd_y};

    plin_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SEGC),
        .i_seg   (w_seg),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_req_type == REQ_EVAL)) begin
                        r_sample <= i_sample_x;
                        if (32'(w_n) < 32'd2) begin
                            r_done   <= 1'b1;
                            r_value  <= '0;
                            r_status <= ST_FEW;
                        end else begin
                            r_state <= S_RD0;
                        end
                    end
                end
                S_RD0: begin
                    r_state <= S_CHK0;
                end
                S_CHK0: begin
                    if (r_sample <= w_rd_x) begin
                        r_seg_i <= '0;
                        r_state <= S_SEGA;
                    end else begin
                        r_state <= S_CHKL;
                    end
                end
                S_CHKL: begin
                    if (r_sample >= w_rd_x) begin
                        r_seg_i <= AW'(w_n - NW'(2));
                        r_state <= S_SEGA;
                    end else begin
                        r_state <= S_SCAN0;
                    end
                end
                S_SCAN0: begin
                    r_k     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_k != '0 && r_prev <= r_sample && r_sample <= w_rd_x) begin
                        r_seg_i <= AW'(r_k - 1'b1);
                        r_state <= S_SEGA;
                    end else if (32'(r_k) == 32'(w_n) - 32'd1) begin
                        r_done   <= 1'b1;
                        r_value  <= '0;
                        r_status <= ST_NOSEG;
                        r_state  <= S_IDLE;
                    end else begin
                        r_prev <= w_rd_x;
                        r_k    <= AW'(r_k + 1'b1);
                    end
                end
                S_SEGA: begin
                    r_state <= S_SEGB;
                end
                S_SEGB: begin
                    r_x0    <= w_rd_x;
                    r_y0    <= w_rd_y;
                    r_state <= S_SEGC;
                end
                S_SEGC: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_rsp.done) begin
                        r_done   <= 1'b1;
                        r_value  <= w_rsp.value;
                        r_status <= w_rsp.status;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (w_cfg_wr && (paddr[2] == REG_POINT_COUNT)) begin
            r_point_count <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_POINT_COUNT) ? PDATA_W'(r_point_count) : '0;
    assign pready = 1'b1;

    assign o_done         = r_done;
    assign o_mapped_value = r_value;
    assign o_status       = r_status;

endmodule

FILE: rtl/core/plin_tbl.sv
// ----------------------------------------------------------------------------
// plin_tbl
// Breakpoint memory, one (x, y) row per entry, registered read.
// ----------------------------------------------------------------------------
module plin_tbl #(
    parameter int MAX_POINTS = plin_pkg::MAX_POINTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_en,
    input  logic [$clog2(MAX_POINTS)-1:0]        i_wr_addr,
    input  logic signed [plin_pkg::DATA_W-1:0]   i_wr_x,
    input  logic signed [plin_pkg::DATA_W-1:0]   i_wr_y,
    input  logic [$clog2(MAX_POINTS)-1:0]        i_rd_addr,
    output logic signed [plin_pkg::DATA_W-1:0]   o_rd_x,
    output logic signed [plin_pkg::DATA_W-1:0]   o_rd_y
);
    import plin_pkg::*;

    logic [2*DATA_W-1:0] r_mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] r_vld;
    logic [2*DATA_W-1:0] r_rd_row;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_x, i_wr_y};
        end
        r_rd_row <= r_mem[i_rd_addr];
        r_rd_vld <= r_vld[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_x = r_rd_vld ? r_rd_row[2*DATA_W-1:DATA_W] : '0;
    assign o_rd_y = r_rd_vld ? r_rd_row[DATA_W-1:0]        : '0;

endmodule

FILE: rtl/core/plin_arith.sv
// ----------------------------------------------------------------------------
// plin_arith
// Segment evaluator: differences, one multiply, bit-serial restoring divide,
// round to nearest and saturate; a zero-width segment returns y0.
// ----------------------------------------------------------------------------
module plin_arith (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  plin_pkg::t_seg       i_seg,
    output plin_pkg::t_arith_rsp o_rsp
);
    import plin_pkg::*;

    localparam int PW = 2 * DATA_W;

    typedef enum logic [2:0] {
        A_IDLE,
        A_DIFF,
        A_MUL,
        A_DIV,
        A_RND,
        A_SAT
    } t_astate;

    t_astate            r_state;
    t_seg               r_seg;
    logic [DATA_W-1:0]  r_mdx;
    logic [DATA_W-1:0]  r_mdy;
    logic [DATA_W-1:0]  r_mdw;
    logic               r_neg;
    logic [PW-1:0]      r_p;
    logic [DATA_W-1:0]  r_rem;
    logic [$clog2(PW)-1:0] r_cnt;
    t_arith_rsp         r_rsp;

    logic signed [DATA_W:0]   w_dx;
    logic signed [DATA_W:0]   w_dy;
    logic signed [DATA_W:0]   w_dw;
    logic [DATA_W:0]          w_adx;
    logic [DATA_W:0]          w_ady;
    logic [DATA_W:0]          w_adw;
    logic [DATA_W:0]          w_rem_sh;
    logic                     w_ge;
    logic [DATA_W:0]          w_rem_nx;
    logic                     w_up;
    logic signed [DATA_W+2:0] w_y0e;
    logic signed [DATA_W+2:0] w_q;
    logic signed [DATA_W+2:0] w_sum;
    logic                     w_big;
    logic signed [DATA_W-1:0] w_sat;

    assign w_dx  = {r_seg.x[DATA_W-1], r_seg.x}   - {r_seg.x0[DATA_W-1], r_seg.x0};
    assign w_dy  = {r_seg.y1[DATA_W-1], r_seg.y1} - {r_seg.y0[DATA_W-1], r_seg.y0};
    assign w_dw  = {r_seg.x1[DATA_W-1], r_seg.x1} - {r_seg.x0[DATA_W-1], r_seg.x0};
    assign w_adx = w_dx[DATA_W] ? -w_dx : w_dx;
    assign w_ady = w_dy[DATA_W] ? -w_dy : w_dy;
    assign w_adw = w_dw[DATA_W] ? -w_dw : w_dw;

    assign w_rem_sh = {r_rem, r_p[PW-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_mdw};
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_mdw}) : w_rem_sh;

    assign w_up = {r_rem, 1'b0} >= {1'b0, r_mdw};

    assign w_big = |r_p[PW-1:DATA_W+1];
    assign w_y0e = {{3{r_seg.y0[DATA_W-1]}}, r_seg.y0};
    assign w_q   = {2'b00, r_p[DATA_W:0]};
    assign w_sum = r_neg ? (w_y0e - w_q) : (w_y0e + w_q);

    always_comb begin
        if (w_big) begin
            w_sat = r_neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else if (w_sum[DATA_W+2:DATA_W-1] == '0 || w_sum[DATA_W+2:DATA_W-1] == '1) begin
            w_sat = w_sum[DATA_W-1:0];
        end else if (w_sum[DATA_W+2]) begin
            w_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= A_IDLE;
            r_rsp.done <= 1'b0;
        end else begin
            r_rsp.done <= 1'b0;
            case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        r_seg   <= i_seg;
                        r_state <= A_DIFF;
                    end
                end
                A_DIFF: begin
                    if (w_dw == '0) begin
                        r_rsp.done   <= 1'b1;
                        r_rsp.value  <= r_seg.y0;
                        r_rsp.status <= ST_ZERO;
                        r_state      <= A_IDLE;
                    end else begin
                        r_mdx   <= w_adx[DATA_W-1:0];
                        r_mdy   <= w_ady[DATA_W-1:0];
                        r_mdw   <= w_adw[DATA_W-1:0];
                        r_neg   <= w_dx[DATA_W] ^ w_dy[DATA_W] ^ w_dw[DATA_W];
                        r_state <= A_MUL;
                    end
                end
                A_MUL: begin
                    r_p     <= PW'(r_mdx) * PW'(r_mdy);
                    r_rem   <= '0;
                    r_cnt   <= '1;
                    r_state <= A_DIV;
                end
                A_DIV: begin
                    r_p   <= {r_p[PW-2:0], w_ge};
                    r_rem <= w_rem_nx[DATA_W-1:0];
                    if (r_cnt == '0) begin
                        r_state <= A_RND;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                A_RND: begin
                    r_p     <= r_p + PW'(w_up);
                    r_state <= A_SAT;
                end
                A_SAT: begin
                    r_rsp.done   <= 1'b1;
                    r_rsp.value  <= w_sat;
                    r_rsp.status <= ST_OK;
                    r_state      <= A_IDLE;
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_rsp = r_rsp;

endmodule

FILE: rtl/core/plin_chk.sv
// ----------------------------------------------------------------------------
// plin_chk
// Port-level checks of the interpolator command and result channels.
// ----------------------------------------------------------------------------
module plin_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               i_req_type,
    input logic                               o_done,
    input logic signed [plin_pkg::DATA_W-1:0] o_mapped_value,
    input logic [plin_pkg::STATUS_W-1:0]      o_status
);
    import plin_pkg::*;

    a_eval_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type == REQ_EVAL) |=> (busy || o_done))
        else $error("evaluate transaction neither started nor answered");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type == REQ_WRITE) |=> (!busy && !o_done))
        else $error("write transaction produced activity");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_fell_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    a_zero_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FEW || o_status == ST_NOSEG))
            |-> (o_mapped_value == '0))
        else $error("failed evaluation with nonzero value");

endmodule

bind piecewise_linear_interpolator_top plin_chk u_plin_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_req_type     (i_req_type),
    .o_done         (o_done),
    .o_mapped_value (o_mapped_value),
    .o_status       (o_status)
);
